>>> design/uartrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uartrb_pkg;

    localparam int RX_DEPTH  = 256;
    localparam int TX_DEPTH  = 128;
    localparam int RX_AW     = $clog2(RX_DEPTH);
    localparam int TX_AW     = $clog2(TX_DEPTH);
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 3;
    localparam int RX_CNT_W  = 8;
    localparam int TX_CNT_W  = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef enum logic [ACT_W-1:0] {
        ACT_RX_BYTE  = 3'd0,
        ACT_HOST_RD  = 3'd1,
        ACT_HOST_WR  = 3'd2,
        ACT_TX_READY = 3'd3,
        ACT_STATUS   = 3'd4
    } action_t;

    typedef struct packed {
        logic                rx_rd;
        logic                tx_emit;
        logic [RX_CNT_W-1:0] rx_count;
        logic [TX_CNT_W-1:0] tx_count;
        logic                tx_irq;
    } step_info_t;

    typedef struct packed {
        logic tx_en;
        logic tx_empty;
    } ring_status_t;

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_CNT_W-1:0] rx_fill(input logic [RX_AW-1:0] h,
                                                     input logic [RX_AW-1:0] t);
        logic [RX_AW:0] d;
        d = {1'b0, h} - {1'b0, t};
        if (h < t) d = d + (RX_AW + 1)'(RX_DEPTH);
        return RX_CNT_W'(d[RX_AW-1:0]);
    endfunction

    function automatic logic [TX_CNT_W-1:0] tx_fill(input logic [TX_AW-1:0] h,
                                                     input logic [TX_AW-1:0] t);
        logic [TX_AW:0] d;
        d = {1'b0, h} - {1'b0, t};
        if (h < t) d = d + (TX_AW + 1)'(TX_DEPTH);
        return TX_CNT_W'(d[TX_AW-1:0]);
    endfunction

endpackage

`default_nettype wire

>>> design/uartrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module uartrb_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/uartrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module uartrb_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire uartrb_pkg::action_t           action,
    input  wire logic [uartrb_pkg::BYTE_W-1:0] data_byte,
    output uartrb_pkg::step_info_t             info,
    output uartrb_pkg::ring_status_t           status,
    output logic      [uartrb_pkg::BYTE_W-1:0] rx_q,
    output logic                               rx_q_vld,
    output logic      [uartrb_pkg::BYTE_W-1:0] tx_q,
    output logic                               tx_q_vld
);

    logic [uartrb_pkg::RX_AW-1:0]    rx_head_reg, rx_head_next;
    logic [uartrb_pkg::RX_AW-1:0]    rx_tail_reg, rx_tail_next;
    logic [uartrb_pkg::TX_AW-1:0]    tx_head_reg, tx_head_next;
    logic [uartrb_pkg::TX_AW-1:0]    tx_tail_reg, tx_tail_next;
    logic                            tx_en_reg, tx_en_next;
    logic                            rx_wrap_reg;
    logic                            tx_wrap_reg;
    logic                            rx_q_vld_reg;
    logic                            tx_q_vld_reg;

    logic                            rx_we, rx_re, tx_we, tx_re;
    logic                            rx_rd_act, tx_emit_act;
    logic [uartrb_pkg::TX_AW-1:0]    tx_head_inc, tx_tail_inc;

    assign tx_head_inc = uartrb_pkg::tx_inc(tx_head_reg);
    assign tx_tail_inc = uartrb_pkg::tx_inc(tx_tail_reg);

    always_comb begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_en_next   = tx_en_reg;
        rx_rd_act    = 1'b0;
        tx_emit_act  = 1'b0;
        unique case (action)
            uartrb_pkg::ACT_RX_BYTE: begin
                rx_head_next = uartrb_pkg::rx_inc(rx_head_reg);
            end
            uartrb_pkg::ACT_HOST_RD: begin
                rx_rd_act = 1'b1;
                if (rx_head_reg != rx_tail_reg) begin
                    rx_tail_next = uartrb_pkg::rx_inc(rx_tail_reg);
                end
            end
            uartrb_pkg::ACT_HOST_WR: begin
                tx_head_next = tx_head_inc;
                tx_en_next   = 1'b1;
            end
            uartrb_pkg::ACT_TX_READY: begin
                if (tx_en_reg) begin
                    if (tx_head_reg != tx_tail_reg) begin
                        tx_emit_act  = 1'b1;
                        tx_tail_next = tx_tail_inc;
                    end
                    tx_en_next = (tx_tail_next != tx_head_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign rx_we = accept && (action == uartrb_pkg::ACT_RX_BYTE);
    assign tx_we = accept && (action == uartrb_pkg::ACT_HOST_WR);
    assign rx_re = accept && rx_rd_act;
    assign tx_re = accept && tx_emit_act;

    assign info.rx_rd    = rx_rd_act;
    assign info.tx_emit  = tx_emit_act;
    assign info.rx_count = uartrb_pkg::rx_fill(rx_head_next, rx_tail_next);
    assign info.tx_count = uartrb_pkg::tx_fill(tx_head_next, tx_tail_next);
    assign info.tx_irq   = tx_en_next;

    assign status.tx_en    = tx_en_reg;
    assign status.tx_empty = (tx_head_reg == tx_tail_reg);

    // entries are written in address order from reset, so an entry holds data
    // once the write pointer has passed it or has wrapped once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_en_reg    <= 1'b0;
            rx_wrap_reg  <= 1'b0;
            tx_wrap_reg  <= 1'b0;
            rx_q_vld_reg <= 1'b0;
            tx_q_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                tx_en_reg   <= tx_en_next;
            end
            if (rx_we && (rx_head_reg == uartrb_pkg::RX_AW'(uartrb_pkg::RX_DEPTH - 1))) begin
                rx_wrap_reg <= 1'b1;
            end
            if (tx_we && (tx_head_inc == '0)) begin
                tx_wrap_reg <= 1'b1;
            end
            if (rx_re) begin
                rx_q_vld_reg <= rx_wrap_reg || (rx_tail_reg != rx_head_reg);
            end
            if (tx_re) begin
                tx_q_vld_reg <= tx_wrap_reg ||
                                ((tx_tail_inc != '0) && (tx_tail_inc <= tx_head_reg));
            end
        end
    end

    assign rx_q_vld = rx_q_vld_reg;
    assign tx_q_vld = tx_q_vld_reg;

    uartrb_ram #(
        .DEPTH (uartrb_pkg::RX_DEPTH),
        .WIDTH (uartrb_pkg::BYTE_W)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_head_reg),
        .wr_data (data_byte),
        .rd_en   (rx_re),
        .rd_addr (rx_tail_reg),
        .rd_data (rx_q)
    );

    uartrb_ram #(
        .DEPTH (uartrb_pkg::TX_DEPTH),
        .WIDTH (uartrb_pkg::BYTE_W)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_head_inc),
        .wr_data (data_byte),
        .rd_en   (tx_re),
        .rd_addr (tx_tail_inc),
        .rd_data (tx_q)
    );

endmodule

`default_nettype wire

>>> design/uart_rx_tx_ring_buffers_core.sv
// Each input beat goes through the stage register (RAM read), then the output register.
// Throughput: one beat per cycle unless m_tready stalls; pointer update and RAM read pace it.
// Each beat does at most one access per ring RAM, so no forwarding is needed.
// Reset: synchronous, active low; clears pointers, enable and one wrap flag per ring, so
// entries not yet written since reset read as zero at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_tx_ring_buffers_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // action[2:0], data_byte[10:3], zero[15:11]
    input  wire logic [uartrb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_byte[7:0], rx_count[15:8], tx_count[22:16], tx_valid[23],
    // tx_byte[31:24], tx_irq_on[32], zero[39:33]
    output logic      [uartrb_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                                accept;
    logic                                out_free;
    uartrb_pkg::step_info_t              info;
    uartrb_pkg::ring_status_t            ring_st;
    logic [uartrb_pkg::BYTE_W-1:0]       rx_q, tx_q;
    logic                                rx_q_vld, tx_q_vld;

    logic                                stg_vld_reg, stg_vld_next;
    uartrb_pkg::step_info_t              stg_info_reg;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [uartrb_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [uartrb_pkg::BYTE_W-1:0]       read_byte, tx_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !stg_vld_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    uartrb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .action    (uartrb_pkg::action_t'(s_tdata[uartrb_pkg::ACT_W-1:0])),
        .data_byte (s_tdata[uartrb_pkg::ACT_W +: uartrb_pkg::BYTE_W]),
        .info      (info),
        .status    (ring_st),
        .rx_q      (rx_q),
        .rx_q_vld  (rx_q_vld),
        .tx_q      (tx_q),
        .tx_q_vld  (tx_q_vld)
    );

    // zero the bytes of unwritten entries and of beats that read nothing
    assign read_byte = (stg_info_reg.rx_rd && rx_q_vld) ? rx_q : '0;
    assign tx_byte   = (stg_info_reg.tx_emit && tx_q_vld) ? tx_q : '0;

    always_comb begin
        stg_vld_next = stg_vld_reg;
        if (accept) begin
            stg_vld_next = 1'b1;
        end else if (out_free) begin
            stg_vld_next = 1'b0;
        end
        m_tvalid_next = out_free ? stg_vld_reg : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_free && stg_vld_reg) begin
            m_tdata_next = {7'd0, stg_info_reg.tx_irq, tx_byte, stg_info_reg.tx_emit,
                            stg_info_reg.tx_count, stg_info_reg.rx_count, read_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            stg_vld_reg  <= stg_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_info_reg <= info;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> stg_vld_reg)
        else $error("accepted beat did not reach the stage");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (stg_vld_reg && !out_free) |-> !s_tready)
        else $error("input ready while stage is blocked");

    a_irq_off_means_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !ring_st.tx_en |-> ring_st.tx_empty)
        else $error("transmit ring holds bytes with interrupt enable clear");

endmodule

`default_nettype wire

>>> test/uart_rx_tx_ring_buffers_core_tb.sv
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_core_tb;
    import uartrb_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_STATUS + 1'b1;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;

    typedef struct packed {
        logic                tx_irq_on;
        logic [BYTE_W-1:0]   tx_byte;
        logic                tx_valid;
        logic [TX_CNT_W-1:0] tx_count;
        logic [RX_CNT_W-1:0] rx_count;
        logic [BYTE_W-1:0]   read_byte;
    } ring_report_t;

    localparam int REPORT_W = $bits(ring_report_t);

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    uart_rx_tx_ring_buffers_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of both rings
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [RX_AW-1:0]  rx_wr_ptr = '0;
    logic [RX_AW-1:0]  rx_rd_ptr = '0;
    logic [TX_AW-1:0]  tx_wr_ptr = '0;
    logic [TX_AW-1:0]  tx_rd_ptr = '0;
    logic              tx_irq_en = 1'b0;

    ring_report_t ring_reports_q[$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("uart_rx_tx_ring_buffers_core_tb NOT OK");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic ring_report_t ring_step(input logic [ACT_W-1:0] act,
                                               input logic [BYTE_W-1:0] data);
        ring_report_t r;
        r = '0;
        case (act)
            ACT_RX_BYTE: begin
                rx_mem[rx_wr_ptr] = data;
                rx_wr_ptr = rx_wr_ptr + 1'b1;
            end
            ACT_HOST_RD: begin
                r.read_byte = rx_mem[rx_rd_ptr];
                if (rx_wr_ptr != rx_rd_ptr) rx_rd_ptr = rx_rd_ptr + 1'b1;
            end
            ACT_HOST_WR: begin
                tx_wr_ptr = tx_wr_ptr + 1'b1;
                tx_mem[tx_wr_ptr] = data;
                tx_irq_en = 1'b1;
            end
            ACT_TX_READY: begin
                if (tx_irq_en) begin
                    if (tx_wr_ptr != tx_rd_ptr) begin
                        tx_rd_ptr = tx_rd_ptr + 1'b1;
                        r.tx_byte = tx_mem[tx_rd_ptr];
                        r.tx_valid = 1'b1;
                    end
                    if (tx_rd_ptr == tx_wr_ptr) tx_irq_en = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.rx_count = RX_CNT_W'(rx_wr_ptr - rx_rd_ptr);
        r.tx_count = TX_CNT_W'(tx_wr_ptr - tx_rd_ptr);
        r.tx_irq_on = tx_irq_en;
        return r;
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data);
        bit placed;
        placed = 1'b0;
        while (!placed) begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W - ACT_W - BYTE_W){1'b0}}, data, act};
                placed = 1'b1;
            end
        end
        do @(posedge aclk); while (!s_tready);
        ring_reports_q.push_back(ring_step(act, data));
    endtask

    task automatic note_mismatch(input string field, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, seen);
    endtask

    always @(posedge aclk) begin
        ring_report_t got;
        ring_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[REPORT_W-1:0];
            if (ring_reports_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat %h with nothing expected", $realtime, m_tdata);
            end else begin
                want = ring_reports_q.pop_front();
                if (got.read_byte !== want.read_byte)
                    note_mismatch("read_byte", want.read_byte, got.read_byte);
                if (got.rx_count !== want.rx_count)
                    note_mismatch("rx_count", want.rx_count, got.rx_count);
                if (got.tx_count !== want.tx_count)
                    note_mismatch("tx_count", BYTE_W'(want.tx_count), BYTE_W'(got.tx_count));
                if (got.tx_valid !== want.tx_valid)
                    note_mismatch("tx_valid", BYTE_W'(want.tx_valid), BYTE_W'(got.tx_valid));
                if (got.tx_byte !== want.tx_byte)
                    note_mismatch("tx_byte", want.tx_byte, got.tx_byte);
                if (got.tx_irq_on !== want.tx_irq_on)
                    note_mismatch("tx_irq_on", BYTE_W'(want.tx_irq_on),
                                  BYTE_W'(got.tx_irq_on));
                if (m_tdata[M_TDATA_W-1:REPORT_W] !== '0)
                    note_mismatch("pad", '0, BYTE_W'(m_tdata[M_TDATA_W-1:REPORT_W]));
            end
        end
    end

    task automatic test_idle_status();
        send_beat(ACT_STATUS, 8'hFF);
        send_beat(ACT_UNUSED_LO, 8'h00);
        send_beat(ACT_UNUSED_LO + 1'b1, 8'hAA);
        send_beat(ACT_UNUSED_HI, 8'h55);
        send_beat(ACT_HOST_RD, 8'h00);
        send_beat(ACT_TX_READY, 8'hFF);
    endtask

    task automatic test_rx_ring();
        send_beat(ACT_RX_BYTE, 8'h00);
        send_beat(ACT_RX_BYTE, 8'hFF);
        send_beat(ACT_RX_BYTE, 8'hA5);
        repeat (3) send_beat(ACT_HOST_RD, 8'h00);
        send_beat(ACT_HOST_RD, 8'h00);
    endtask

    task automatic test_tx_ring();
        send_beat(ACT_HOST_WR, 8'hFF);
        send_beat(ACT_HOST_WR, 8'h00);
        send_beat(ACT_TX_READY, 8'h00);
        send_beat(ACT_TX_READY, 8'h00);
        send_beat(ACT_TX_READY, 8'h00);
        send_beat(ACT_HOST_WR, 8'h5A);
        send_beat(ACT_TX_READY, 8'hA5);
    endtask

    task automatic test_rx_overflow();
        repeat (RX_DEPTH) send_beat(ACT_RX_BYTE, BYTE_W'($urandom));
        send_beat(ACT_HOST_RD, BYTE_W'($urandom));
        repeat (4) send_beat(ACT_RX_BYTE, BYTE_W'($urandom));
        repeat (5) send_beat(ACT_HOST_RD, BYTE_W'($urandom));
    endtask

    task automatic test_tx_overflow();
        repeat (TX_DEPTH) send_beat(ACT_HOST_WR, BYTE_W'($urandom));
        send_beat(ACT_TX_READY, BYTE_W'($urandom));
        send_beat(ACT_TX_READY, BYTE_W'($urandom));
        repeat (3) send_beat(ACT_HOST_WR, BYTE_W'($urandom));
        repeat (4) send_beat(ACT_TX_READY, BYTE_W'($urandom));
    endtask

    task automatic test_random(input int n);
        int               pick;
        logic [ACT_W-1:0] act;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      act = ACT_RX_BYTE;
            else if (pick < 45) act = ACT_HOST_RD;
            else if (pick < 65) act = ACT_HOST_WR;
            else if (pick < 85) act = ACT_TX_READY;
            else if (pick < 93) act = ACT_STATUS;
            else                act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            send_beat(act, BYTE_W'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < RX_DEPTH; i++) rx_mem[i] = '0;
        for (int i = 0; i < TX_DEPTH; i++) tx_mem[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_status();
        test_rx_ring();
        test_tx_ring();
        test_rx_overflow();

        send_idle_pct = 56;
        test_tx_overflow();
        test_random(40);

        send_idle_pct = 0;
        recv_stall_pct = 56;
        test_random(70);

        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(70);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (ring_reports_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && ring_reports_q.size() == 0) begin
            $display("uart_rx_tx_ring_buffers_core_tb OK");
        end else begin
            $display("uart_rx_tx_ring_buffers_core_tb NOT OK");
        end
        $finish;
    end

endmodule
